[rtl/lfp_pkg.sv]
package lfp_pkg;

    localparam int GRAY_W   = 10;
    localparam int GAIN_W   = 24;
    localparam int CFG_W    = 24;
    localparam int SAMPLE_W = 10;
    localparam int SPEED_W  = 8;
    localparam int ERR_W    = 11;
    localparam int DIFF_W   = 12;
    localparam int SUM_W    = 32;
    localparam int CNT_W    = 4;
    localparam int FRAC_W   = 16;

    localparam int PKP_W = GAIN_W + 1 + ERR_W;
    localparam int PKI_W = GAIN_W + 1 + SUM_W;
    localparam int PKD_W = GAIN_W + 1 + DIFF_W;
    localparam int ACC_W = PKI_W + 2;
    localparam int QUO_W = ACC_W - FRAC_W;

    localparam int RAMP_TICKS_DEF = 10;

    localparam logic [GRAY_W-1:0] GRAY_RST = 10'd512;
    localparam logic [GAIN_W-1:0] KP_RST   = 24'd121242;
    localparam logic [GAIN_W-1:0] KI_RST   = 24'd85;
    localparam logic [GAIN_W-1:0] KD_RST   = 24'd393216;

    localparam logic signed [SPEED_W-1:0] SPEED_MAX = 8'sd100;
    localparam logic signed [SPEED_W-1:0] SPEED_MIN = -8'sd100;

    typedef enum logic [1:0] {
        REG_GRAY = 2'd0,
        REG_KP   = 2'd1,
        REG_KI   = 2'd2,
        REG_KD   = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0]        light_sample;
        logic signed [SPEED_W-1:0]  target_speed;
        logic                       restart;
    } sample_t;

    typedef struct packed {
        logic signed [SPEED_W-1:0]  turn_cmd;
        logic signed [SPEED_W-1:0]  forward_cmd;
    } cmd_t;

endpackage

[rtl/line_follow_pid_with_speed_ramp.sv]
// Channel   Valid         Stall         Word
// -------   -----------   -----------   -----------------------------------------
// sample    sample_valid  sample_stall  light_sample, target_speed, restart
// cmd       cmd_valid     cmd_stall     turn_cmd, forward_cmd
//
// Four register stages: input, error/integral/ramp, products, result.
// Words pass the error, product and result stages; one taken per cycle unless sample_stall.
// The error history and the speed ramp update as a word leaves the input stage.
// rst_n clears the stage valids, the history, the ramp and loads the register defaults.
// A stalled cmd holds; earlier stages keep filling bubbles before sample_stall rises.
module line_follow_pid_with_speed_ramp
    import lfp_pkg::*;
#(
    parameter int RAMP_TICKS = RAMP_TICKS_DEF
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_stall,
    input  sample_t           sample,
    output logic              cmd_valid,
    input  logic              cmd_stall,
    output cmd_t              cmd,
    input  logic              cfg_write,
    input  cfg_index_t        cfg_index,
    input  logic [CFG_W-1:0]  cfg_data
);

    logic [GRAY_W-1:0] gray_reg;
    logic [GAIN_W-1:0] kp_reg;
    logic [GAIN_W-1:0] ki_reg;
    logic [GAIN_W-1:0] kd_reg;

    logic signed [SUM_W-1:0]   sum_reg,  sum_next;
    logic signed [ERR_W-1:0]   last_reg, last_next;
    logic signed [SPEED_W-1:0] fwd_reg,  fwd_next;
    logic [CNT_W-1:0]          cnt_reg,  cnt_next;

    logic                       v0_reg, v1_reg, v2_reg, v3_reg;
    logic                       ld0, ld1, ld2, ld3;
    sample_t                    s0_reg;

    logic signed [ERR_W-1:0]    e1_reg;
    logic signed [SUM_W-1:0]    sum1_reg;
    logic signed [DIFF_W-1:0]   d1_reg;
    logic signed [SPEED_W-1:0]  fwd1_reg;

    logic signed [PKP_W-1:0]    pkp2_reg;
    logic signed [PKI_W-1:0]    pki2_reg;
    logic signed [PKD_W-1:0]    pkd2_reg;
    logic signed [SPEED_W-1:0]  fwd2_reg;

    cmd_t                       cmd_reg, cmd_next;

    logic signed [ERR_W-1:0]    err;
    logic signed [SUM_W-1:0]    hist_sum;
    logic signed [ERR_W-1:0]    hist_last;
    logic signed [SUM_W:0]      sum_wide;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [SPEED_W-1:0]  lim;
    logic [CNT_W-1:0]           cnt_inc;
    logic signed [SPEED_W-1:0]  fwd_up, fwd_dn;
    logic                       adv0;

    logic signed [ACC_W-1:0]    acc;
    logic signed [QUO_W-1:0]    quo;
    logic signed [QUO_W:0]      neg;

    assign ld3 = !v3_reg || !cmd_stall;
    assign ld2 = !v2_reg || ld3;
    assign ld1 = !v1_reg || ld2;
    assign ld0 = !v0_reg || ld1;
    assign adv0 = v0_reg && ld1;

    assign sample_stall = !ld0;
    assign cmd_valid    = v3_reg;
    assign cmd          = cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gray_reg <= GRAY_RST;
            kp_reg   <= KP_RST;
            ki_reg   <= KI_RST;
            kd_reg   <= KD_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_GRAY: gray_reg <= cfg_data[GRAY_W-1:0];
                REG_KP:   kp_reg   <= cfg_data[GAIN_W-1:0];
                REG_KI:   ki_reg   <= cfg_data[GAIN_W-1:0];
                REG_KD:   kd_reg   <= cfg_data[GAIN_W-1:0];
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        hist_sum  = s0_reg.restart ? '0 : sum_reg;
        hist_last = s0_reg.restart ? '0 : last_reg;

        if (s0_reg.target_speed > 0)
            err = $signed({1'b0, gray_reg}) - $signed({1'b0, s0_reg.light_sample});
        else
            err = $signed({1'b0, s0_reg.light_sample}) - $signed({1'b0, gray_reg});

        sum_wide = {hist_sum[SUM_W-1], hist_sum}
                 + {{(SUM_W+1-ERR_W){err[ERR_W-1]}}, err};
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
            sum_next = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                       : {1'b0, {(SUM_W-1){1'b1}}};
        else
            sum_next = sum_wide[SUM_W-1:0];

        diff = {err[ERR_W-1], err} - {hist_last[ERR_W-1], hist_last};
        last_next = err;

        if (s0_reg.target_speed > SPEED_MAX)
            lim = SPEED_MAX;
        else if (s0_reg.target_speed < SPEED_MIN)
            lim = SPEED_MIN;
        else
            lim = s0_reg.target_speed;

        cnt_inc = cnt_reg + 1'b1;
        fwd_up  = fwd_reg + 8'sd1;
        fwd_dn  = fwd_reg - 8'sd1;
        cnt_next = cnt_inc;
        fwd_next = fwd_reg;
        if (cnt_inc >= CNT_W'(RAMP_TICKS))
        begin
            cnt_next = '0;
            if (lim >= fwd_reg)
                fwd_next = (fwd_up > lim) ? lim : fwd_up;
            else
                fwd_next = (fwd_dn < lim) ? lim : fwd_dn;
        end
    end

    always_comb
    begin
        acc = ACC_W'(pkp2_reg) + ACC_W'(pki2_reg) + ACC_W'(pkd2_reg);
        quo = acc[ACC_W-1:FRAC_W];
        if (acc[ACC_W-1] && (acc[FRAC_W-1:0] != '0))
            quo = quo + 1'b1;
        neg = -{quo[QUO_W-1], quo};
        cmd_next.forward_cmd = fwd2_reg;
        if (neg > (QUO_W+1)'(SPEED_MAX))
            cmd_next.turn_cmd = SPEED_MAX;
        else if (neg < (QUO_W+1)'(SPEED_MIN))
            cmd_next.turn_cmd = SPEED_MIN;
        else
            cmd_next.turn_cmd = neg[SPEED_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            sum_reg  <= '0;
            last_reg <= '0;
            fwd_reg  <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (ld0)
                v0_reg <= sample_valid;
            if (ld1)
                v1_reg <= v0_reg;
            if (ld2)
                v2_reg <= v1_reg;
            if (ld3)
                v3_reg <= v2_reg;
            if (adv0)
            begin
                sum_reg  <= sum_next;
                last_reg <= last_next;
                fwd_reg  <= fwd_next;
                cnt_reg  <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld0 && sample_valid)
            s0_reg <= sample;
        if (adv0)
        begin
            e1_reg   <= err;
            sum1_reg <= sum_next;
            d1_reg   <= diff;
            fwd1_reg <= fwd_next;
        end
        if (ld2 && v1_reg)
        begin
            pkp2_reg <= $signed({1'b0, kp_reg}) * e1_reg;
            pki2_reg <= $signed({1'b0, ki_reg}) * sum1_reg;
            pkd2_reg <= $signed({1'b0, kd_reg}) * d1_reg;
            fwd2_reg <= fwd1_reg;
        end
        if (ld3 && v2_reg)
            cmd_reg <= cmd_next;
    end

endmodule

[rtl/lfp_checker.sv]
module lfp_checker
    import lfp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    input  logic              sample_stall,
    input  sample_t           sample,
    input  logic              cmd_valid,
    input  logic              cmd_stall,
    input  cmd_t              cmd
);

    a_cmd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_stall |=> cmd_valid && $stable(cmd))
        else $error("stalled cmd word changed");

    a_sample_hold: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_stall |=> sample_valid && $stable(sample))
        else $error("stalled sample word changed");

    a_turn_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid |-> (cmd.turn_cmd <= SPEED_MAX) && (cmd.turn_cmd >= SPEED_MIN))
        else $error("turn_cmd out of range");

    a_fwd_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid |-> (cmd.forward_cmd <= SPEED_MAX) && (cmd.forward_cmd >= SPEED_MIN))
        else $error("forward_cmd out of range");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_valid |-> !sample_stall)
        else $error("sample stalled while cmd side is empty");

endmodule

bind line_follow_pid_with_speed_ramp lfp_checker u_lfp_checker (.*);

[tb/line_follow_pid_with_speed_ramp_test.sv]
module line_follow_pid_with_speed_ramp_test;
    import lfp_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 300;
    localparam int SEG_ITEMS      = 275;

    typedef struct packed {
        sample_t w;
        logic    fixed;
        cmd_t    want;
    } step_row_t;

    logic             clk;
    logic             rst_n = 1'b0;
    logic             sample_valid = 1'b0;
    logic             sample_stall;
    sample_t          sample = '0;
    logic             cmd_valid;
    logic             cmd_stall = 1'b0;
    cmd_t             cmd;
    logic             cfg_write = 1'b0;
    cfg_index_t       cfg_index = REG_GRAY;
    logic [CFG_W-1:0] cfg_data = '0;

    cmd_t      cmd_due[$];
    step_row_t dir_rows[$];
    cmd_t      want_cmd;

    int gray_cfg = int'(GRAY_RST);
    int kp_cfg   = int'(KP_RST);
    int ki_cfg   = int'(KI_RST);
    int kd_cfg   = int'(KD_RST);

    int integ      = 0;
    int prev_err   = 0;
    int fwd_speed  = 0;
    int tick_count = 0;
    int cruise_tgt = 0;

    int feed_idle_pct  = 0;
    int drain_idle_pct = 0;
    int hold_asks      = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;
    int mismatches     = 0;

    line_follow_pid_with_speed_ramp u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .cmd          (cmd),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic cmd_t steer_and_ramp(input sample_t w);
        int     tgt;
        int     lim;
        int     smp;
        int     e;
        int     d;
        longint s;
        longint acc;
        longint q;
        cmd_t   r;
        tgt = w.target_speed;
        smp = w.light_sample;
        if (w.restart)
        begin
            integ = 0;
            prev_err = 0;
        end
        lim = (tgt > 100) ? 100 : ((tgt < -100) ? -100 : tgt);
        tick_count = (tick_count + 1) % 16;
        if (tick_count >= RAMP_TICKS_DEF)
        begin
            tick_count = 0;
            if (lim >= fwd_speed)
            begin
                fwd_speed++;
                if (fwd_speed > lim)
                    fwd_speed = lim;
            end
            else
            begin
                fwd_speed--;
                if (fwd_speed < lim)
                    fwd_speed = lim;
            end
        end
        e = (tgt > 0) ? gray_cfg - smp : smp - gray_cfg;
        s = longint'(integ) + longint'(e);
        if (s > 64'sd2147483647)
            s = 64'sd2147483647;
        if (s < -64'sd2147483648)
            s = -64'sd2147483648;
        integ = int'(s);
        d = e - prev_err;
        acc = longint'(kp_cfg) * e + longint'(ki_cfg) * integ + longint'(kd_cfg) * d;
        q = -(acc / 64'sd65536);
        if (q > 100)
            q = 100;
        if (q < -100)
            q = -100;
        prev_err = e;
        r.turn_cmd = SPEED_W'(q);
        r.forward_cmd = SPEED_W'(fwd_speed);
        return r;
    endfunction

    function automatic sample_t pick_word();
        sample_t w;
        int      v;
        if ($urandom_range(99) < 2)
            cruise_tgt = ($urandom_range(1) == 1) ? int'($urandom_range(10)) - 5
                                                  : int'($urandom_range(200)) - 100;
        case ($urandom_range(9))
            0: v = 0;
            1: v = 1023;
            2, 3: v = gray_cfg + int'($urandom_range(20)) - 10;
            default: v = int'($urandom_range(1023));
        endcase
        if (v < 0)
            v = 0;
        if (v > 1023)
            v = 1023;
        w.light_sample = SAMPLE_W'(v);
        w.target_speed = ($urandom_range(9) == 0) ? SPEED_W'($urandom_range(255))
                                                  : SPEED_W'(cruise_tgt);
        w.restart = ($urandom_range(99) < 3);
        return w;
    endfunction

    task automatic flag_cmd(input string what, input int got, input int want);
        mismatches++;
        $display("cmd mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    endtask

    task automatic add_row(input logic [SAMPLE_W-1:0] smp, input int tgt, input logic rst,
                           input logic fixed, input int turn, input int fwd);
        step_row_t r;
        r.w.light_sample = smp;
        r.w.target_speed = SPEED_W'(tgt);
        r.w.restart = rst;
        r.fixed = fixed;
        r.want.turn_cmd = SPEED_W'(turn);
        r.want.forward_cmd = SPEED_W'(fwd);
        dir_rows.push_back(r);
    endtask

    task automatic send_word(input sample_t w, input logic fixed, input cmd_t want);
        cmd_t pred;
        while ($urandom_range(99) < feed_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample <= w;
        sample_valid <= 1'b1;
        do
            @(posedge clk);
        while (sample_stall !== 1'b0);
        pred = steer_and_ramp(w);
        cmd_due.push_back(fixed ? want : pred);
    endtask

    // drop valid and wait out every word still in flight
    task automatic settle(input int margin);
        sample_valid <= 1'b0;
        do
            @(posedge clk);
        while (cmd_due.size() != 0);
        repeat (margin) @(posedge clk);
    endtask

    task automatic load_regs(input int gray, input int kp, input int ki, input int kd);
        cfg_write <= 1'b1;
        cfg_index <= REG_GRAY;
        cfg_data <= CFG_W'(gray);
        @(posedge clk);
        cfg_index <= REG_KP;
        cfg_data <= CFG_W'(kp);
        @(posedge clk);
        cfg_index <= REG_KI;
        cfg_data <= CFG_W'(ki);
        @(posedge clk);
        cfg_index <= REG_KD;
        cfg_data <= CFG_W'(kd);
        @(posedge clk);
        cfg_write <= 1'b0;
        gray_cfg = gray;
        kp_cfg = kp;
        ki_cfg = ki;
        kd_cfg = kd;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && cmd_valid === 1'b1 && cmd_stall === 1'b0)
        begin
            if (cmd_due.size() == 0)
            begin
                flag_cmd("unexpected word, turn_cmd", cmd.turn_cmd, 0);
            end
            else
            begin
                want_cmd = cmd_due.pop_front();
                if (cmd.turn_cmd !== want_cmd.turn_cmd)
                    flag_cmd("turn_cmd", cmd.turn_cmd, want_cmd.turn_cmd);
                if (cmd.forward_cmd !== want_cmd.forward_cmd)
                    flag_cmd("forward_cmd", cmd.forward_cmd, want_cmd.forward_cmd);
            end
        end
        if (hold_asks != hold_seen)
        begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            cmd_stall <= 1'b1;
        end
        else
        begin
            cmd_stall <= ($urandom_range(99) < drain_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((sample_valid && !sample_stall) || (cmd_valid && !cmd_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        int seg;
        int n;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset gains: gray 512, large kp and kd, so most errors clamp
        add_row(10'd512,     0, 1'b0, 1'b1,    0, 0);
        add_row(10'd0,     100, 1'b0, 1'b1, -100, 0);
        add_row(10'd1023, -128, 1'b0, 1'b1, -100, 0);
        add_row(10'd1023,    0, 1'b1, 1'b1, -100, 0);
        add_row(10'd0,       0, 1'b0, 1'b1,  100, 0);
        add_row(10'd0,     127, 1'b0, 1'b0, 0, 0);
        add_row(10'd1023,  127, 1'b0, 1'b0, 0, 0);
        add_row(10'd1023, -100, 1'b0, 1'b0, 0, 0);
        add_row(10'd0,    -100, 1'b0, 1'b0, 0, 0);
        add_row(10'd512,     1, 1'b0, 1'b0, 0, 0);
        add_row(10'd512,    -1, 1'b1, 1'b0, 0, 0);
        add_row(10'd513,   100, 1'b0, 1'b0, 0, 0);
        add_row(10'd511,    -1, 1'b0, 1'b0, 0, 0);
        add_row(10'd0,    -128, 1'b1, 1'b0, 0, 0);
        add_row(10'd1023,  100, 1'b1, 1'b0, 0, 0);
        add_row(10'd700,   100, 1'b0, 1'b0, 0, 0);
        add_row(10'd300,  -100, 1'b0, 1'b0, 0, 0);
        add_row(10'd0,     100, 1'b0, 1'b0, 0, 0);
        add_row(10'd1023, -128, 1'b0, 1'b0, 0, 0);
        add_row(10'd512,  -100, 1'b0, 1'b0, 0, 0);
        add_row(10'd256,   127, 1'b0, 1'b0, 0, 0);
        add_row(10'd768,  -128, 1'b1, 1'b0, 0, 0);

        feed_idle_pct = 34;
        drain_idle_pct = 57;
        foreach (dir_rows[i])
            send_word(dir_rows[i].w, dir_rows[i].fixed, dir_rows[i].want);
        settle(8);

        for (seg = 0; seg < 6; seg++)
        begin
            feed_idle_pct = (seg < 2) ? 34 : ((seg < 4) ? 57 : 0);
            drain_idle_pct = (seg < 2) ? 57 : ((seg < 4) ? 34 : 0);
            case (seg)
                0: load_regs(int'(GRAY_RST), int'(KP_RST), int'(KI_RST), int'(KD_RST));
                1: load_regs(0, 16777215, 16777215, 16777215);
                2: load_regs(1023, 0, 0, 0);
                default: load_regs(int'($urandom_range(1023)), int'($urandom_range(8000)),
                                   int'($urandom_range(40)), int'($urandom_range(6000)));
            endcase
            for (n = 0; n < SEG_ITEMS; n++)
            begin
                // hold the cmd side long enough to back up the pipe
                if (seg == 0 && n == 100)
                    hold_asks++;
                if (seg == 1 && n == 60)
                begin
                    sample_valid <= 1'b0;
                    do
                        @(posedge clk);
                    while (cmd_due.size() != 0);
                end
                send_word(pick_word(), 1'b0, '0);
            end
            settle(8);
        end

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
